/* sv/twcw_pkg.sv */
// Shared types and constants of the text window character writer.
// No dependencies; imported by twcw_plan and text_window_char_writer_unit.
package twcw_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_TAB_STOP = 8;

    // width of row and column counts, enough for 256 plus one step past the edge
    localparam int CNT_W = 9;

    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_HT  = 8'd9;
    localparam logic [7:0] CODE_LF  = 8'd10;
    localparam logic [7:0] CODE_FF  = 8'd12;
    localparam logic [7:0] CODE_CR  = 8'd13;
    localparam logic [7:0] CODE_SP  = 8'd32;
    localparam logic [7:0] CODE_DEL = 8'd127;
    localparam logic [7:0] STANDOUT_BIT = 8'h80;

    localparam logic [2:0] CFG_ROWS     = 3'd0;
    localparam logic [2:0] CFG_COLS     = 3'd1;
    localparam logic [2:0] CFG_TOP      = 3'd2;
    localparam logic [2:0] CFG_WRAP     = 3'd3;
    localparam logic [2:0] CFG_OVERFLOW = 3'd4;
    localparam logic [2:0] CFG_STANDOUT = 3'd5;
    localparam logic [2:0] CFG_INSERT   = 3'd6;

    localparam logic [1:0] MODE_STAY   = 2'd0;
    localparam logic [1:0] MODE_SCROLL = 2'd1;
    localparam logic [1:0] MODE_PAGE   = 2'd2;

    typedef enum logic [1:0] {
        SC_NONE,
        SC_UP,
        SC_DOWN,
        SC_PAGE
    } t_scroll;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_PUT,
        S_COPY,
        S_BLANK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [6:0] rows_in_use;
        logic [7:0] cols_in_use;
        logic [5:0] scroll_top;
        logic       wrap_enable;
        logic [1:0] overflow_mode;
        logic       standout_enable;
        logic       insert_enable;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] nrows;
        logic [CNT_W-1:0] ncols;
        logic [CNT_W-1:0] rtop;
        logic [CNT_W-1:0] cur_row;
        logic [CNT_W-1:0] cur_col;
        logic [CNT_W-1:0] put_row;
        logic [CNT_W-1:0] put_col;
        logic [7:0]       put_char;
        logic             do_put;
        logic             do_insert;
        t_scroll          scroll;
    } t_plan;

endpackage

/* sv/text_window_char_writer_unit.sv */
// Text window character writer: cell memory, sequencer and request/result ports.
// Depends on twcw_pkg and twcw_plan.
//
// The sequencer takes one request at a time and accepts the next only when
// idle. A control code that only moves the cursor goes straight to the
// result; a read request reads the cell first, and a plain character writes
// its cell. Insert first moves the cells from the cursor onward one place
// right in the row. A one-line scroll copies (region rows - 1) rows of cells
// and then blanks one row. A page turn blanks the region at one cell a cycle.
// All of this is set by the single cell memory, which does one read and one
// write per cycle. A result held by a stalled output holds the sequencer until
// it is taken. After reset the memory is filled with spaces, one cell a cycle,
// over all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells. No request is accepted
// then, while configuration writes are taken at any time.
module text_window_char_writer_unit import twcw_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int TAB_STOP = DEF_TAB_STOP
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_char_code,
    input  logic [5:0] i_read_row,
    input  logic [6:0] i_read_col,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [5:0] o_cursor_row,
    output logic [6:0] o_cursor_col,
    output logic [7:0] o_read_char,
    output logic       o_scrolled
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RW + CW;

    function automatic logic [AW-1:0] cell_addr(input logic [CNT_W-1:0] row,
                                                input logic [CNT_W-1:0] col);
        return {row[RW-1:0], col[CW-1:0]};
    endfunction

    t_cfg             r_cfg;
    t_state           r_state, n_state;
    t_plan            p, r_plan, pl;
    logic [RW-1:0]    r_cur_row;
    logic [CW-1:0]    r_cur_col;
    logic [CNT_W-1:0] r_r, r_c;
    logic [AW-1:0]    r_clr;
    logic             r_wb_valid;
    logic [AW-1:0]    r_wb_addr;
    logic [7:0]       r_rd_q;
    logic             r_rd_ok;
    logic [7:0]       r_res_char;
    logic             r_out_valid;
    logic [5:0]       r_out_row;
    logic [6:0]       r_out_col;
    logic [7:0]       r_out_char;
    logic             r_out_scrolled;

    logic             in_acc;
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [7:0]       mem_wdata;
    logic             copy_needed;
    logic             copy_last, blank_last, shift_last;
    logic [CNT_W-1:0] blank_end;
    t_state           after_put;

    logic [7:0] mem [2**AW];

    twcw_plan #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS),
        .TAB_STOP(TAB_STOP)
    ) u_plan (
        .i_cfg      (r_cfg),
        .i_kind     (i_kind),
        .i_char_code(i_char_code),
        .i_cur_row  (CNT_W'(r_cur_row)),
        .i_cur_col  (CNT_W'(r_cur_col)),
        .o_plan     (p)
    );

    assign o_cfg_ready  = 1'b1;
    assign o_in_stall   = (r_state != S_IDLE);
    assign in_acc       = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;
    assign o_read_char  = r_out_char;
    assign o_scrolled   = r_out_scrolled;

    always_comb begin
        pl = (r_state == S_IDLE) ? p : r_plan;
        copy_needed = (pl.rtop + 1'b1 < pl.nrows);
        blank_end   = (pl.scroll == SC_DOWN) ? pl.rtop : pl.nrows - 1'b1;
        shift_last  = (r_c - 1'b1 == pl.put_col);
        copy_last   = (r_c == pl.ncols - 1'b1) &&
                      ((pl.scroll == SC_UP) ? (r_r + 2'd2 == pl.nrows)
                                            : (r_r == pl.rtop + 1'b1));
        blank_last  = (r_c == pl.ncols - 1'b1) && (r_r == blank_end);
        if ((pl.scroll == SC_UP || pl.scroll == SC_DOWN) && copy_needed) begin
            after_put = S_COPY;
        end else if (pl.scroll != SC_NONE) begin
            after_put = S_BLANK;
        end else begin
            after_put = S_DONE;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (&r_clr) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    if (i_kind) begin
                        n_state = S_READ;
                    end else if (p.do_insert && (p.put_col + 1'b1 < p.ncols)) begin
                        n_state = S_SHIFT;
                    end else if (p.do_put) begin
                        n_state = S_PUT;
                    end else begin
                        n_state = after_put;
                    end
                end
            end
            S_READ:  n_state = S_DONE;
            S_SHIFT: if (shift_last) n_state = S_PUT;
            S_PUT:   if (!r_wb_valid) n_state = after_put;
            S_COPY:  if (copy_last) n_state = S_BLANK;
            S_BLANK: if (!r_wb_valid && blank_last) n_state = S_DONE;
            S_DONE:  if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wb_addr;
        mem_wdata = r_rd_q;
        mem_re    = 1'b0;
        mem_raddr = cell_addr(CNT_W'(i_read_row), CNT_W'(i_read_col));
        if (r_wb_valid) begin
            mem_we = 1'b1;
        end
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = CODE_SP;
            end
            S_IDLE: mem_re = in_acc && i_kind;
            S_SHIFT: begin
                mem_re    = 1'b1;
                mem_raddr = cell_addr(pl.put_row, r_c - 1'b1);
            end
            S_PUT: begin
                if (!r_wb_valid) begin
                    mem_we    = 1'b1;
                    mem_waddr = cell_addr(pl.put_row, pl.put_col);
                    mem_wdata = pl.put_char;
                end
            end
            S_COPY: begin
                mem_re    = 1'b1;
                mem_raddr = (pl.scroll == SC_UP) ? cell_addr(r_r + 1'b1, r_c)
                                                 : cell_addr(r_r - 1'b1, r_c);
            end
            S_BLANK: begin
                if (!r_wb_valid) begin
                    mem_we    = 1'b1;
                    mem_waddr = cell_addr(r_r, r_c);
                    mem_wdata = CODE_SP;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rd_q <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_cfg.rows_in_use     <= 7'd24;
            r_cfg.cols_in_use     <= 8'd80;
            r_cfg.scroll_top      <= 6'd0;
            r_cfg.wrap_enable     <= 1'b1;
            r_cfg.overflow_mode   <= MODE_SCROLL;
            r_cfg.standout_enable <= 1'b0;
            r_cfg.insert_enable   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROWS:     r_cfg.rows_in_use     <= i_cfg_data[6:0];
                    CFG_COLS:     r_cfg.cols_in_use     <= i_cfg_data;
                    CFG_TOP:      r_cfg.scroll_top      <= i_cfg_data[5:0];
                    CFG_WRAP:     r_cfg.wrap_enable     <= i_cfg_data[0];
                    CFG_OVERFLOW: r_cfg.overflow_mode   <= i_cfg_data[1:0];
                    CFG_STANDOUT: r_cfg.standout_enable <= i_cfg_data[0];
                    CFG_INSERT:   r_cfg.insert_enable   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            r_wb_valid <= (r_state == S_SHIFT) || (r_state == S_COPY);
            if (in_acc) begin
                r_cur_row <= RW'(p.cur_row);
                r_cur_col <= CW'(p.cur_col);
            end
            if (r_state == S_DONE && n_state == S_IDLE) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sequencer counters and payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_plan     <= p;
            r_res_char <= '0;
            r_rd_ok    <= (CNT_W'(i_read_row) < p.nrows) && (CNT_W'(i_read_col) < p.ncols);
        end
        if (r_state == S_READ) r_res_char <= r_rd_ok ? r_rd_q : 8'd0;
        case (r_state)
            S_SHIFT: r_wb_addr <= cell_addr(pl.put_row, r_c);
            S_COPY:  r_wb_addr <= cell_addr(r_r, r_c);
            default: ;
        endcase
        // load counters on entry to a sweep, else advance them
        if (n_state == S_SHIFT && r_state != S_SHIFT) begin
            r_c <= pl.ncols - 1'b1;
        end else if (n_state == S_COPY && r_state != S_COPY) begin
            r_r <= (pl.scroll == SC_UP) ? pl.rtop : pl.nrows - 1'b1;
            r_c <= '0;
        end else if (n_state == S_BLANK && r_state != S_BLANK) begin
            r_r <= (pl.scroll == SC_UP) ? pl.nrows - 1'b1 : pl.rtop;
            r_c <= '0;
        end else begin
            case (r_state)
                S_SHIFT: r_c <= r_c - 1'b1;
                S_COPY: begin
                    if (r_c == pl.ncols - 1'b1) begin
                        r_c <= '0;
                        r_r <= (pl.scroll == SC_UP) ? r_r + 1'b1 : r_r - 1'b1;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_BLANK: begin
                    if (!r_wb_valid) begin
                        if (r_c == pl.ncols - 1'b1) begin
                            r_c <= '0;
                            r_r <= r_r + 1'b1;
                        end else begin
                            r_c <= r_c + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (r_state == S_DONE && n_state == S_IDLE) begin
            r_out_row      <= 6'(r_cur_row);
            r_out_col      <= 7'(r_cur_col);
            r_out_char     <= r_res_char;
            r_out_scrolled <= (r_plan.scroll != SC_NONE);
        end
    end

endmodule

/* sv/twcw_plan.sv */
// Cursor and control code decode: window clamping, cursor motion, scroll choice.
// Depends on twcw_pkg.
module twcw_plan import twcw_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int TAB_STOP = DEF_TAB_STOP
) (
    input  t_cfg             i_cfg,
    input  logic             i_kind,
    input  logic [7:0]       i_char_code,
    input  logic [CNT_W-1:0] i_cur_row,
    input  logic [CNT_W-1:0] i_cur_col,
    output t_plan            o_plan
);

    localparam int NTAB = MAX_COLS / TAB_STOP;

    logic [CNT_W-1:0] nrows, ncols, rtop, cr, cc, pc, nx;
    logic [1:0]       mode;
    logic             nl, do_put;
    t_scroll          sc;

    always_comb begin
        nrows = (i_cfg.rows_in_use == 7'd0) ? CNT_W'(1) :
                (CNT_W'(i_cfg.rows_in_use) > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) :
                CNT_W'(i_cfg.rows_in_use);
        ncols = (i_cfg.cols_in_use == 8'd0) ? CNT_W'(1) :
                (CNT_W'(i_cfg.cols_in_use) > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) :
                CNT_W'(i_cfg.cols_in_use);
        rtop = (CNT_W'(i_cfg.scroll_top) >= nrows) ? nrows - 1'b1 : CNT_W'(i_cfg.scroll_top);
        mode = (i_cfg.overflow_mode == 2'd3) ? MODE_STAY : i_cfg.overflow_mode;
        cr = (i_cur_row >= nrows) ? nrows - 1'b1 : i_cur_row;
        cc = (i_cur_col >= ncols) ? ncols - 1'b1 : i_cur_col;
        pc = cc;
        nx = CNT_W'(TAB_STOP);
        nl = 1'b0;
        do_put = 1'b0;
        sc = SC_NONE;

        if (!i_kind) begin
            case (i_char_code)
                CODE_CR: cc = '0;
                CODE_LF: nl = 1'b1;
                CODE_BS: begin
                    if (cc != '0) begin
                        cc = cc - 1'b1;
                    end else if (i_cfg.wrap_enable) begin
                        cc = ncols - 1'b1;
                        if (cr <= rtop) begin
                            case (mode)
                                MODE_SCROLL: begin
                                    sc = SC_DOWN;
                                    cr = rtop;
                                end
                                MODE_PAGE: begin
                                    sc = SC_PAGE;
                                    cr = nrows - 1'b1;
                                end
                                default: cr = rtop;
                            endcase
                        end else begin
                            cr = cr - 1'b1;
                        end
                    end
                end
                CODE_HT: begin
                    for (int m = 1; m <= NTAB; m++) begin
                        if (CNT_W'(m * TAB_STOP) <= cc) nx = CNT_W'((m + 1) * TAB_STOP);
                    end
                    cc = (nx > ncols) ? ncols : nx;
                end
                CODE_FF: begin
                    if (mode == MODE_PAGE) begin
                        cc = '0;
                        sc = SC_PAGE;
                        cr = rtop;
                    end
                end
                default: begin
                    if (i_char_code >= CODE_SP && i_char_code != CODE_DEL) begin
                        do_put = 1'b1;
                        cc = cc + 1'b1;
                    end
                end
            endcase

            // past the right edge: wrap to the next line or hold at the last column
            if (cc >= ncols) begin
                if (i_cfg.wrap_enable) begin
                    cc = '0;
                    nl = 1'b1;
                end else begin
                    cc = ncols - 1'b1;
                end
            end

            if (nl) begin
                if (cr + 1'b1 >= nrows) begin
                    case (mode)
                        MODE_SCROLL: sc = SC_UP;
                        MODE_PAGE: begin
                            sc = SC_PAGE;
                            cr = rtop;
                        end
                        default: ;
                    endcase
                end else begin
                    cr = cr + 1'b1;
                end
            end
        end

        o_plan.nrows     = nrows;
        o_plan.ncols     = ncols;
        o_plan.rtop      = rtop;
        o_plan.cur_row   = cr;
        o_plan.cur_col   = cc;
        o_plan.put_row   = (i_cur_row >= nrows) ? nrows - 1'b1 : i_cur_row;
        o_plan.put_col   = pc;
        o_plan.put_char  = i_cfg.standout_enable ? (i_char_code | STANDOUT_BIT) : i_char_code;
        o_plan.do_put    = do_put;
        o_plan.do_insert = do_put & i_cfg.insert_enable;
        o_plan.scroll    = sc;
    end

endmodule
